### src/lusr_pkg.sv
package lusr_pkg;

  // field widths
  localparam int unsigned QB_W   = 32;  // queue depth in bytes
  localparam int unsigned K_W    = 40;  // backpressure constant k
  localparam int unsigned Q88_W  = 16;  // unsigned Q8.8 values
  localparam int unsigned RATE_W = 34;  // send rate and rate cap
  localparam int unsigned CFG_W  = 40;  // widest register
  localparam int unsigned CIDX_W = 2;

  // derived datapath widths
  localparam int unsigned KP_W   = K_W + Q88_W;        // k*p
  localparam int unsigned T_W    = KP_W + Q88_W;       // k*p*a, scaled by 2^16
  localparam int unsigned QS_W   = QB_W + 19;          // bytes*8 scaled by 2^16
  localparam int unsigned DVS_W  = QB_W + Q88_W;       // a*bytes
  localparam int unsigned HI_W   = T_W - 45;           // dividend bits above the quotient
  localparam int unsigned DIV_STEPS = RATE_W;          // one quotient bit per step

  // register reset values
  localparam logic [K_W-1:0]    K_RST    = '0;
  localparam logic [Q88_W-1:0]  PRIO_RST = 16'd256;
  localparam logic [Q88_W-1:0]  GAIN_RST = 16'd256;
  localparam logic [RATE_W-1:0] MAX_RST  = 34'd1000000;

  // configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_K    = 2'd0,
    CFG_PRIO = 2'd1,
    CFG_GAIN = 2'd2,
    CFG_MAX  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [QB_W-1:0] queue_bytes;
    logic            paused;
  } in_item_t;

  typedef struct packed {
    logic [RATE_W-1:0] tx_rate;
    logic              blocked;
  } out_item_t;

  // one item in the divider chain
  typedef struct packed {
    logic                 valid;
    logic                 off;
    logic                 blocked;
    logic                 use_max;
    logic [DVS_W-1:0]     rem;
    logic [DVS_W-1:0]     dvs;
    logic [RATE_W-1:0]    num;
    logic [RATE_W-1:0]    quo;
  } div_t;

endpackage

### src/lusr_if.sv
interface lusr_in_if;
  logic               valid;
  logic               ready;
  lusr_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lusr_out_if;
  logic                valid;
  logic                ready;
  lusr_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/lusr_prep.sv
module lusr_prep (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  lusr_pkg::in_item_t               in_item,
  input  logic [lusr_pkg::K_W-1:0]         k_value,
  input  logic [lusr_pkg::Q88_W-1:0]       priority_cfg,
  input  logic [lusr_pkg::Q88_W-1:0]       gain,
  output lusr_pkg::div_t                   dout
);

  // stage 1: input register
  logic                        v1;
  logic [lusr_pkg::QB_W-1:0]   qb1;
  logic                        off1;

  // stage 2: products with the registers
  logic                        v2;
  logic                        off2;
  logic                        qzero2;
  logic [lusr_pkg::KP_W-1:0]   kp2;
  logic [lusr_pkg::DVS_W-1:0]  dvs2;
  logic [lusr_pkg::QS_W-1:0]   qs2;

  // stage 3: threshold
  logic                        v3;
  logic                        off3;
  logic                        qzero3;
  logic [lusr_pkg::T_W-1:0]    t3;
  logic [lusr_pkg::DVS_W-1:0]  dvs3;
  logic [lusr_pkg::QS_W-1:0]   qs3;

  // stage 4: threshold compare and dividend
  logic                        v4;
  logic                        off4;
  logic                        qzero4;
  logic                        blk4;
  logic [lusr_pkg::HI_W-1:0]   hi4;
  logic [lusr_pkg::RATE_W-1:0] lo4;
  logic [lusr_pkg::DVS_W-1:0]  dvs4;

  logic [lusr_pkg::T_W:0]      diff;
  logic                        blk_next;
  logic [lusr_pkg::DVS_W-1:0]  hi_ext;
  logic                        sat;

  // threshold minus scaled depth, borrow means the depth is past it
  assign diff     = {1'b0, t3} - {{(lusr_pkg::T_W + 1 - lusr_pkg::QS_W){1'b0}}, qs3};
  assign blk_next = diff[lusr_pkg::T_W] | (diff[lusr_pkg::T_W-1:0] == '0);

  // quotient at or above 2^34 always hits the cap
  assign hi_ext = {{(lusr_pkg::DVS_W - lusr_pkg::HI_W){1'b0}}, hi4};
  assign sat    = hi_ext >= dvs4;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      dout.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      dout.valid <= v4;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      qb1  <= in_item.queue_bytes;
      off1 <= in_item.paused;

      off2   <= off1;
      qzero2 <= (qb1 == '0);
      kp2    <= {{(lusr_pkg::KP_W - lusr_pkg::K_W){1'b0}}, k_value}
              * {{(lusr_pkg::KP_W - lusr_pkg::Q88_W){1'b0}}, priority_cfg};
      dvs2   <= {{(lusr_pkg::DVS_W - lusr_pkg::Q88_W){1'b0}}, gain}
              * {{(lusr_pkg::DVS_W - lusr_pkg::QB_W){1'b0}}, qb1};
      qs2    <= {qb1, 19'd0};

      off3   <= off2;
      qzero3 <= qzero2;
      t3     <= {{(lusr_pkg::T_W - lusr_pkg::KP_W){1'b0}}, kp2}
              * {{(lusr_pkg::T_W - lusr_pkg::Q88_W){1'b0}}, gain};
      dvs3   <= dvs2;
      qs3    <= qs2;

      off4   <= off3;
      qzero4 <= qzero3;
      blk4   <= blk_next;
      hi4    <= diff[lusr_pkg::T_W-1:45];
      lo4    <= diff[44:11];
      dvs4   <= dvs3;

      dout.off     <= off4;
      dout.blocked <= blk4 & ~off4;
      dout.use_max <= qzero4 | sat;
      dout.rem     <= sat ? '0 : hi_ext;
      dout.dvs     <= dvs4;
      dout.num     <= lo4;
      dout.quo     <= '0;
    end
  end

endmodule

### src/lusr_div_step.sv
module lusr_div_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  lusr_pkg::div_t din,
  output lusr_pkg::div_t dout
);

  logic [lusr_pkg::DVS_W:0] rr;
  logic [lusr_pkg::DVS_W:0] sub;
  logic                     ge;

  // one restoring step: bring down the next dividend bit
  assign rr  = {din.rem, din.num[lusr_pkg::RATE_W-1]};
  assign sub = rr - {1'b0, din.dvs};
  assign ge  = rr >= {1'b0, din.dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.off     <= din.off;
      dout.blocked <= din.blocked;
      dout.use_max <= din.use_max;
      dout.dvs     <= din.dvs;
      dout.rem     <= ge ? sub[lusr_pkg::DVS_W-1:0] : rr[lusr_pkg::DVS_W-1:0];
      dout.num     <= {din.num[lusr_pkg::RATE_W-2:0], 1'b0};
      dout.quo     <= {din.quo[lusr_pkg::RATE_W-2:0], ge};
    end
  end

endmodule

### src/lusr_outbuf.sv
module lusr_outbuf (
  input  logic                        clk,
  input  logic                        rst,
  input  lusr_pkg::div_t              din,
  input  logic [lusr_pkg::RATE_W-1:0] max_rate,
  input  logic                        out_ready,
  output logic                        out_valid,
  output lusr_pkg::out_item_t         out_item,
  output logic                        skid_valid
);

  lusr_pkg::out_item_t new_item;
  lusr_pkg::out_item_t skid_item;
  logic                take;
  logic                load;

  // final rate: flow off or blocked gives 0, otherwise quotient under the cap
  always_comb begin
    new_item.blocked = din.blocked;
    if (din.off || din.blocked) begin
      new_item.tx_rate = '0;
    end else if (din.use_max || (din.quo >= max_rate)) begin
      new_item.tx_rate = max_rate;
    end else begin
      new_item.tx_rate = din.quo;
    end
  end

  // the chain only moves while the skid slot is empty
  assign take = din.valid & ~skid_valid;
  assign load = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load) begin
      out_valid  <= skid_valid | take;
      skid_valid <= 1'b0;
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= skid_valid ? skid_item : new_item;
    end else if (take) begin
      skid_item <= new_item;
    end
  end

endmodule

### src/log_utility_send_rate.sv
// channel  dir  payload                                  transfer
// in       in   queue_bytes[31:0], paused                valid & ready
// out      out  tx_rate[33:0], blocked                   valid & ready
// cfg      in   cfg_index[1:0], cfg_data[39:0]           cfg_we
//
// one item per cycle while the skid slot is empty; 5 setup stages (products, threshold
// compare), 34 restoring divider steps (one quotient bit each), 1 output register
// a skid slot behind the output register keeps items flowing while out stalls;
// the whole chain holds only while that slot is full
// rst is synchronous: clears valid bits and loads the register defaults
module log_utility_send_rate (
  input  logic                           clk,
  input  logic                           rst,
  lusr_in_if.sink                        in,
  lusr_out_if.source                     out,
  input  logic                           cfg_we,
  input  logic [lusr_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [lusr_pkg::CFG_W-1:0]     cfg_data
);

  logic [lusr_pkg::K_W-1:0]    k_value;
  logic [lusr_pkg::Q88_W-1:0]  priority_cfg;
  logic [lusr_pkg::Q88_W-1:0]  gain;
  logic [lusr_pkg::RATE_W-1:0] max_rate;

  logic                        en;
  logic                        skid_valid;
  lusr_pkg::div_t              chain [0:lusr_pkg::DIV_STEPS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k_value      <= lusr_pkg::K_RST;
      priority_cfg <= lusr_pkg::PRIO_RST;
      gain         <= lusr_pkg::GAIN_RST;
      max_rate     <= lusr_pkg::MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lusr_pkg::CFG_K:    k_value      <= cfg_data[lusr_pkg::K_W-1:0];
        lusr_pkg::CFG_PRIO: priority_cfg <= cfg_data[lusr_pkg::Q88_W-1:0];
        lusr_pkg::CFG_GAIN: gain         <= cfg_data[lusr_pkg::Q88_W-1:0];
        lusr_pkg::CFG_MAX:  max_rate     <= cfg_data[lusr_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  assign en       = ~skid_valid;
  assign in.ready = en;

  // threshold and dividend setup
  lusr_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (in.valid),
    .in_item      (in.payload),
    .k_value      (k_value),
    .priority_cfg (priority_cfg),
    .gain         (gain),
    .dout         (chain[0])
  );

  // divider chain
  for (genvar i = 0; i < lusr_pkg::DIV_STEPS; i++) begin : g_div
    lusr_div_step u_step (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // cap and output buffering
  lusr_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .din        (chain[lusr_pkg::DIV_STEPS]),
    .max_rate   (max_rate),
    .out_ready  (out.ready),
    .out_valid  (out.valid),
    .out_item   (out.payload),
    .skid_valid (skid_valid)
  );

`ifndef SYNTHESIS
  a_blocked_zero: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.payload.blocked |-> out.payload.tx_rate == '0)
    else $error("blocked result with nonzero rate");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out.valid)
    else $error("skid slot full while output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out.valid && !out.ready))
    else $error("skid slot filled without an output stall");
`endif

endmodule
